>>> sv/rphs_pkg.sv
// Shared types, command codes and constants for the road profile harmonic synthesiser.
`timescale 1ns / 1ps

package rphs_pkg;

    // Fixed-point constants
    localparam logic [31:0] ONE30        = 32'h4000_0000;
    localparam logic [32:0] ONE32        = 33'h1_0000_0000;
    localparam logic [31:0] INV_TWO_PI   = 32'd683565276;
    localparam logic [29:0] HALF_QUAD    = 30'h2000_0000;

    // Configuration register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_TERM_COUNT  = 2'd0;
    localparam logic [1:0] REG_TRACK_END   = 2'd1;
    localparam logic [1:0] REG_FADE_LENGTH = 2'd2;

    // Register reset values
    localparam logic [10:0] TERM_COUNT_RST  = 11'd0;
    localparam logic [31:0] TRACK_END_RST   = 32'd6553600;
    localparam logic [31:0] FADE_LENGTH_RST = 32'd655360;

    // Input item kinds
    localparam logic OP_KIND_LOAD = 1'b0;
    localparam logic OP_KIND_EVAL = 1'b1;

    // Datapath commands
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_RAMP_CHECK,
        OP_DIV_STEP,
        OP_RAMP_ANG,
        OP_COS_PREP,
        OP_MUL_ZZ,
        OP_Z2,
        OP_MUL_HORNER,
        OP_HORNER_SUB,
        OP_MUL_FINAL,
        OP_COS_DONE,
        OP_MUL_SM,
        OP_RAMP_DONE,
        OP_MUL_FADE,
        OP_FADE,
        OP_READ,
        OP_MUL_FX,
        OP_TERM_ANG,
        OP_MUL_AMP,
        OP_ACC,
        OP_MUL_SC_HI,
        OP_SC_HI,
        OP_MUL_SC_LO,
        OP_SC_OUT,
        OP_PUBLISH
    } dp_op_t;

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RCHK,
        ST_RDIV,
        ST_RANG,
        ST_CPREP,
        ST_CMZ,
        ST_CZ2,
        ST_CHM,
        ST_CHS,
        ST_CFM,
        ST_CFS,
        ST_RMSM,
        ST_RDONE,
        ST_FMUL,
        ST_FADE,
        ST_TRD,
        ST_TMX,
        ST_TANG,
        ST_TMA,
        ST_TACC,
        ST_SMH,
        ST_SHI,
        ST_SML,
        ST_SOUT,
        ST_PUB
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t     op;
        logic       track;     // 0 left, 1 right
        logic       ramp_sel;  // 0 rising, 1 falling
        logic [2:0] step;      // Horner coefficient index
    } dp_cmd_t;

    typedef struct packed {
        logic ramp_mid;  // position lies strictly inside the ramp
        logic out_free;  // output register can take a result
    } dp_status_t;

    // Horner coefficients, Q2.30, highest order first
    function automatic logic [31:0] horner_coef(input logic use_cos, input logic [2:0] k);
        logic [31:0] c;
        if (use_cos)
        begin
            case (k)
                3'd0:    c = 32'd506;
                3'd1:    c = 32'd27061;
                3'd2:    c = 32'd987048;
                3'd3:    c = 32'd22401992;
                3'd4:    c = 32'd272375560;
                default: c = 32'd1324675879;
            endcase
        end
        else
        begin
            case (k)
                3'd0:    c = 32'd3864;
                3'd1:    c = 32'd172272;
                3'd2:    c = 32'd5026995;
                3'd3:    c = 32'd85569306;
                3'd4:    c = 32'd693598668;
                default: c = 32'd1686629713;
            endcase
        end
        return c;
    endfunction

endpackage

>>> sv/rphs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module rphs_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/rphs_dp.sv
// Datapath: term table, shared multiplier, divider step, cosine and accumulators.
`timescale 1ns / 1ps

module rphs_dp #(
    parameter int MAX_TERMS = 1024
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  rphs_pkg::dp_cmd_t                               cmd,
    output rphs_pkg::dp_status_t                            status,
    input  logic [(MAX_TERMS > 1 ? $clog2(MAX_TERMS) : 1)-1:0] rd_addr,
    input  logic                                            in_accept,
    input  logic                                            in_op,
    input  logic [9:0]                                      in_term_index,
    input  logic [31:0]                                     in_amplitude,
    input  logic [31:0]                                     in_spatial_frequency,
    input  logic [15:0]                                     in_left_phase,
    input  logic [15:0]                                     in_right_phase,
    input  logic [31:0]                                     in_position_x,
    input  logic [31:0]                                     track_end,
    input  logic [31:0]                                     fade_length,
    output logic                                            out_valid,
    input  logic                                            out_ready,
    output logic [63:0]                                     out_data
);

    localparam int AW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int LG    = $clog2(MAX_TERMS + 1);
    localparam int ACC_W = (LG + 34 > 42) ? LG + 34 : 42;

    // Table memory: {right phase, left phase, frequency, amplitude}
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [95:0]   ram_wdata;
    logic [95:0]   rd;

    assign ram_we    = (cmd.op == rphs_pkg::OP_IDLE) && in_accept &&
                       (in_op == rphs_pkg::OP_KIND_LOAD) &&
                       (32'(in_term_index) < 32'(MAX_TERMS));
    assign ram_waddr = AW'(in_term_index);
    assign ram_wdata = {in_right_phase, in_left_phase, in_spatial_frequency, in_amplitude};

    rphs_ram #(
        .WIDTH(96),
        .DEPTH(MAX_TERMS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.op == rphs_pkg::OP_READ),
        .raddr (rd_addr),
        .rdata (rd)
    );

    logic [31:0]             x_reg, x_next;
    logic [31:0]             rem_reg, rem_next;
    logic [31:0]             quo_reg, quo_next;
    logic [31:0]             ang_reg, ang_next;
    logic [29:0]             z_reg, z_next;
    logic                    use_cos_reg, use_cos_next;
    logic                    cneg_reg, cneg_next;
    logic [31:0]             z2_reg, z2_next;
    logic [31:0]             h_reg, h_next;
    logic [30:0]             c_reg, c_next;
    logic [32:0]             f1_reg, f1_next;
    logic [32:0]             f2_reg, f2_next;
    logic [32:0]             fade_reg, fade_next;
    logic [31:0]             fx_reg, fx_next;
    logic [63:0]             v_reg, v_next;
    logic [31:0]             res_l_reg, res_l_next;
    logic [31:0]             res_r_reg, res_r_next;
    logic signed [ACC_W-1:0] acc_l_reg, acc_l_next;
    logic signed [ACC_W-1:0] acc_r_reg, acc_r_next;
    logic [63:0]             out_data_reg, out_data_next;
    logic                    out_valid_reg, out_valid_next;
    logic [63:0]             prod_reg;
    logic [31:0]             mul_a, mul_b;

    // Ramp bounds in signed 34-bit metres
    logic signed [33:0] xs, x1, x2;
    logic               at_lo, at_hi;
    logic [33:0]        dpos;

    assign xs    = {2'b00, x_reg};
    assign x2    = cmd.ramp_sel ? {2'b00, track_end} : {2'b00, fade_length};
    assign x1    = cmd.ramp_sel ? ({2'b00, track_end} - {2'b00, fade_length}) : 34'sd0;
    assign at_lo = (xs <= x1);
    assign at_hi = (xs >= x2);
    assign dpos  = xs - x1;

    assign status.ramp_mid = !at_lo && !at_hi;
    assign status.out_free = !out_valid_reg || out_ready;

    // Currently selected accumulator, its magnitude and the fade in Q1.30
    logic signed [ACC_W-1:0] acc_sel;
    logic [ACC_W-1:0]        acc_abs;
    logic [30:0]             fq;

    assign acc_sel = cmd.track ? acc_r_reg : acc_l_reg;
    assign acc_abs = acc_sel[ACC_W-1] ? ACC_W'(-acc_sel) : ACC_W'(acc_sel);
    assign fq      = fade_reg[32:2];

    // Multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            rphs_pkg::OP_MUL_ZZ:
            begin
                mul_a = {2'b00, z_reg};
                mul_b = {2'b00, z_reg};
            end
            rphs_pkg::OP_MUL_HORNER:
            begin
                mul_a = z2_reg;
                mul_b = h_reg;
            end
            rphs_pkg::OP_MUL_FINAL:
            begin
                mul_a = use_cos_reg ? z2_reg : {2'b00, z_reg};
                mul_b = h_reg;
            end
            rphs_pkg::OP_MUL_SM:
            begin
                mul_a = {1'b0, c_reg};
                mul_b = rphs_pkg::INV_TWO_PI;
            end
            rphs_pkg::OP_MUL_FADE:
            begin
                mul_a = f1_reg[31:0];
                mul_b = f2_reg[31:0];
            end
            rphs_pkg::OP_MUL_FX:
            begin
                mul_a = rd[63:32];
                mul_b = x_reg;
            end
            rphs_pkg::OP_MUL_AMP:
            begin
                mul_a = rd[31:0];
                mul_b = {1'b0, c_reg};
            end
            rphs_pkg::OP_MUL_SC_HI:
            begin
                mul_a = 32'(acc_abs[ACC_W-1:40]);
                mul_b = {1'b0, fq};
            end
            rphs_pkg::OP_MUL_SC_LO:
            begin
                mul_a = acc_abs[39:8];
                mul_b = {1'b0, fq};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Working register updates
    logic [29:0]        r_frac;
    logic               r_low;
    logic [32:0]        rem2;
    logic [32:0]        ramp_lo, ramp_hi;
    logic signed [34:0] g;
    logic [32:0]        g33;
    logic [31:0]        fx_val;
    logic [15:0]        ph;
    logic [32:0]        mag;
    logic [63:0]        v2;

    always_comb
    begin
        x_next         = x_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        ang_next       = ang_reg;
        z_next         = z_reg;
        use_cos_next   = use_cos_reg;
        cneg_next      = cneg_reg;
        z2_next        = z2_reg;
        h_next         = h_reg;
        c_next         = c_reg;
        f1_next        = f1_reg;
        f2_next        = f2_reg;
        fade_next      = fade_reg;
        fx_next        = fx_reg;
        v_next         = v_reg;
        res_l_next     = res_l_reg;
        res_r_next     = res_r_reg;
        acc_l_next     = acc_l_reg;
        acc_r_next     = acc_r_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;

        r_frac  = ang_reg[29:0];
        r_low   = (r_frac <= rphs_pkg::HALF_QUAD);
        rem2    = {rem_reg, 1'b0};
        ramp_lo = cmd.ramp_sel ? rphs_pkg::ONE32 : 33'd0;
        ramp_hi = cmd.ramp_sel ? 33'd0 : rphs_pkg::ONE32;
        g       = cneg_reg ? ($signed({3'b000, quo_reg}) + $signed({3'b000, prod_reg[61:30]}))
                           : ($signed({3'b000, quo_reg}) - $signed({3'b000, prod_reg[61:30]}));
        g33     = 33'd0;
        fx_val  = cmd.track ? fx_reg : prod_reg[43:12];
        ph      = cmd.track ? rd[95:80] : rd[79:64];
        mag     = prod_reg[62:30];
        v2      = v_reg + (prod_reg >> 29);

        // Result register drains on a transfer
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (cmd.op)
            rphs_pkg::OP_IDLE:
            begin
                if (in_accept && (in_op == rphs_pkg::OP_KIND_EVAL))
                begin
                    x_next     = in_position_x;
                    acc_l_next = '0;
                    acc_r_next = '0;
                end
            end
            rphs_pkg::OP_RAMP_CHECK:
            begin
                rem_next = dpos[31:0];
                quo_next = '0;
                if (cmd.ramp_sel)
                begin
                    f2_next = at_lo ? ramp_lo : ramp_hi;
                end
                else
                begin
                    f1_next = at_lo ? ramp_lo : ramp_hi;
                end
            end
            rphs_pkg::OP_DIV_STEP:
            begin
                // One restoring division step: quotient bit per cycle
                if (rem2 >= {1'b0, fade_length})
                begin
                    rem_next = 32'(rem2 - {1'b0, fade_length});
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rem2[31:0];
                    quo_next = {quo_reg[30:0], 1'b0};
                end
            end
            rphs_pkg::OP_RAMP_ANG:
            begin
                ang_next = quo_reg - rphs_pkg::ONE30;
            end
            rphs_pkg::OP_COS_PREP:
            begin
                // Fold into a quadrant and then an octant
                z_next       = r_low ? r_frac : 30'(31'(rphs_pkg::ONE30) - {1'b0, r_frac});
                use_cos_next = (!ang_reg[30]) == r_low;
                cneg_next    = ang_reg[31] ^ ang_reg[30];
            end
            rphs_pkg::OP_Z2:
            begin
                z2_next = prod_reg[61:30];
                h_next  = rphs_pkg::horner_coef(use_cos_reg, 3'd0);
            end
            rphs_pkg::OP_HORNER_SUB:
            begin
                h_next = rphs_pkg::horner_coef(use_cos_reg, cmd.step) - prod_reg[61:30];
            end
            rphs_pkg::OP_COS_DONE:
            begin
                c_next = use_cos_reg ? 31'(rphs_pkg::ONE30 - prod_reg[61:30]) : prod_reg[60:30];
            end
            rphs_pkg::OP_RAMP_DONE:
            begin
                // Sine step, clamped to [0, 1]
                if (g < 35'sd0)
                begin
                    g33 = 33'd0;
                end
                else if (g > $signed({2'b00, rphs_pkg::ONE32}))
                begin
                    g33 = rphs_pkg::ONE32;
                end
                else
                begin
                    g33 = g[32:0];
                end
                if (cmd.ramp_sel)
                begin
                    f2_next = rphs_pkg::ONE32 - g33;
                end
                else
                begin
                    f1_next = g33;
                end
            end
            rphs_pkg::OP_FADE:
            begin
                if (f1_reg[32])
                begin
                    fade_next = f2_reg;
                end
                else if (f2_reg[32])
                begin
                    fade_next = f1_reg;
                end
                else
                begin
                    fade_next = {1'b0, prod_reg[63:32]};
                end
            end
            rphs_pkg::OP_TERM_ANG:
            begin
                fx_next  = fx_val;
                ang_next = fx_val + {ph, 16'h0000};
            end
            rphs_pkg::OP_ACC:
            begin
                if (cmd.track)
                begin
                    acc_r_next = cneg_reg ? acc_r_reg - ACC_W'(mag) : acc_r_reg + ACC_W'(mag);
                end
                else
                begin
                    acc_l_next = cneg_reg ? acc_l_reg - ACC_W'(mag) : acc_l_reg + ACC_W'(mag);
                end
            end
            rphs_pkg::OP_SC_HI:
            begin
                v_next = prod_reg << 3;
            end
            rphs_pkg::OP_SC_OUT:
            begin
                // Saturate to signed 32 bits
                if (acc_sel[ACC_W-1])
                begin
                    if (v2 > 64'h8000_0000)
                    begin
                        v2 = 64'h8000_0000;
                    end
                    if (cmd.track)
                    begin
                        res_r_next = (~v2[31:0]) + 32'd1;
                    end
                    else
                    begin
                        res_l_next = (~v2[31:0]) + 32'd1;
                    end
                end
                else
                begin
                    if (v2 > 64'h7FFF_FFFF)
                    begin
                        v2 = 64'h7FFF_FFFF;
                    end
                    if (cmd.track)
                    begin
                        res_r_next = v2[31:0];
                    end
                    else
                    begin
                        res_l_next = v2[31:0];
                    end
                end
            end
            rphs_pkg::OP_PUBLISH:
            begin
                out_data_next  = {res_r_reg, res_l_reg};
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prod_reg     <= 64'(mul_a) * 64'(mul_b);
        x_reg        <= x_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        ang_reg      <= ang_next;
        z_reg        <= z_next;
        use_cos_reg  <= use_cos_next;
        cneg_reg     <= cneg_next;
        z2_reg       <= z2_next;
        h_reg        <= h_next;
        c_reg        <= c_next;
        f1_reg       <= f1_next;
        f2_reg       <= f2_next;
        fade_reg     <= fade_next;
        fx_reg       <= fx_next;
        v_reg        <= v_next;
        res_l_reg    <= res_l_next;
        res_r_reg    <= res_r_next;
        acc_l_reg    <= acc_l_next;
        acc_r_reg    <= acc_r_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Division remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == rphs_pkg::OP_DIV_STEP) |-> (rem_reg < fade_length))
        else $error("divider remainder out of range");

    // Cosine magnitude never exceeds one
    a_cos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == rphs_pkg::OP_MUL_SM) |-> (c_reg <= 31'(rphs_pkg::ONE30)))
        else $error("cosine magnitude above one");

    // A result is only loaded when the output register is free
    a_pub_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == rphs_pkg::OP_PUBLISH) |-> status.out_free)
        else $error("result overwritten");

endmodule

>>> sv/rphs_ctrl.sv
// Controller: sequences ramps, cosine evaluations, the term loop and output scaling.
`timescale 1ns / 1ps

module rphs_ctrl #(
    parameter int MAX_TERMS = 1024
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            in_accept,
    input  logic                                            in_op,
    output logic                                            in_ready,
    input  logic [10:0]                                     term_count,
    input  rphs_pkg::dp_status_t                            status,
    output rphs_pkg::dp_cmd_t                               cmd,
    output logic [(MAX_TERMS > 1 ? $clog2(MAX_TERMS) : 1)-1:0] rd_addr
);

    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW = $clog2(MAX_TERMS + 1);

    rphs_pkg::ctrl_state_t state_reg, state_next;
    logic          ramp_sel_reg, ramp_sel_next;
    logic          track_reg, track_next;
    logic          in_ramp_reg, in_ramp_next;
    logic [4:0]    div_cnt_reg, div_cnt_next;
    logic [2:0]    h_cnt_reg, h_cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] n_clip;

    assign n_clip  = (32'(term_count) > 32'(MAX_TERMS)) ? CW'(MAX_TERMS) : CW'(term_count);
    assign rd_addr = idx_reg[AW-1:0];

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rphs_pkg::ST_IDLE;
            ramp_sel_reg <= 1'b0;
            track_reg    <= 1'b0;
            in_ramp_reg  <= 1'b0;
            div_cnt_reg  <= '0;
            h_cnt_reg    <= '0;
            idx_reg      <= '0;
            n_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ramp_sel_reg <= ramp_sel_next;
            track_reg    <= track_next;
            in_ramp_reg  <= in_ramp_next;
            div_cnt_reg  <= div_cnt_next;
            h_cnt_reg    <= h_cnt_next;
            idx_reg      <= idx_next;
            n_reg        <= n_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next    = state_reg;
        ramp_sel_next = ramp_sel_reg;
        track_next    = track_reg;
        in_ramp_next  = in_ramp_reg;
        div_cnt_next  = div_cnt_reg;
        h_cnt_next    = h_cnt_reg;
        idx_next      = idx_reg;
        n_next        = n_reg;
        in_ready      = 1'b0;
        cmd.op        = rphs_pkg::OP_IDLE;
        cmd.track     = track_reg;
        cmd.ramp_sel  = ramp_sel_reg;
        cmd.step      = h_cnt_reg + 3'd1;

        unique case (state_reg)
            rphs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_accept && (in_op == rphs_pkg::OP_KIND_EVAL))
                begin
                    n_next        = n_clip;
                    ramp_sel_next = 1'b0;
                    in_ramp_next  = 1'b1;
                    state_next    = rphs_pkg::ST_RCHK;
                end
            end
            rphs_pkg::ST_RCHK:
            begin
                cmd.op = rphs_pkg::OP_RAMP_CHECK;
                if (status.ramp_mid)
                begin
                    div_cnt_next = '0;
                    state_next   = rphs_pkg::ST_RDIV;
                end
                else if (!ramp_sel_reg)
                begin
                    ramp_sel_next = 1'b1;
                end
                else
                begin
                    state_next = rphs_pkg::ST_FMUL;
                end
            end
            rphs_pkg::ST_RDIV:
            begin
                cmd.op       = rphs_pkg::OP_DIV_STEP;
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'd31)
                begin
                    state_next = rphs_pkg::ST_RANG;
                end
            end
            rphs_pkg::ST_RANG:
            begin
                cmd.op     = rphs_pkg::OP_RAMP_ANG;
                state_next = rphs_pkg::ST_CPREP;
            end
            rphs_pkg::ST_CPREP:
            begin
                cmd.op     = rphs_pkg::OP_COS_PREP;
                state_next = rphs_pkg::ST_CMZ;
            end
            rphs_pkg::ST_CMZ:
            begin
                cmd.op     = rphs_pkg::OP_MUL_ZZ;
                state_next = rphs_pkg::ST_CZ2;
            end
            rphs_pkg::ST_CZ2:
            begin
                cmd.op     = rphs_pkg::OP_Z2;
                h_cnt_next = '0;
                state_next = rphs_pkg::ST_CHM;
            end
            rphs_pkg::ST_CHM:
            begin
                cmd.op     = rphs_pkg::OP_MUL_HORNER;
                state_next = rphs_pkg::ST_CHS;
            end
            rphs_pkg::ST_CHS:
            begin
                cmd.op     = rphs_pkg::OP_HORNER_SUB;
                h_cnt_next = h_cnt_reg + 3'd1;
                state_next = (h_cnt_reg == 3'd4) ? rphs_pkg::ST_CFM : rphs_pkg::ST_CHM;
            end
            rphs_pkg::ST_CFM:
            begin
                cmd.op     = rphs_pkg::OP_MUL_FINAL;
                state_next = rphs_pkg::ST_CFS;
            end
            rphs_pkg::ST_CFS:
            begin
                cmd.op     = rphs_pkg::OP_COS_DONE;
                state_next = in_ramp_reg ? rphs_pkg::ST_RMSM : rphs_pkg::ST_TMA;
            end
            rphs_pkg::ST_RMSM:
            begin
                cmd.op     = rphs_pkg::OP_MUL_SM;
                state_next = rphs_pkg::ST_RDONE;
            end
            rphs_pkg::ST_RDONE:
            begin
                cmd.op = rphs_pkg::OP_RAMP_DONE;
                if (!ramp_sel_reg)
                begin
                    ramp_sel_next = 1'b1;
                    state_next    = rphs_pkg::ST_RCHK;
                end
                else
                begin
                    state_next = rphs_pkg::ST_FMUL;
                end
            end
            rphs_pkg::ST_FMUL:
            begin
                cmd.op     = rphs_pkg::OP_MUL_FADE;
                state_next = rphs_pkg::ST_FADE;
            end
            rphs_pkg::ST_FADE:
            begin
                cmd.op       = rphs_pkg::OP_FADE;
                idx_next     = '0;
                track_next   = 1'b0;
                in_ramp_next = 1'b0;
                state_next   = (n_reg == '0) ? rphs_pkg::ST_SMH : rphs_pkg::ST_TRD;
            end
            rphs_pkg::ST_TRD:
            begin
                cmd.op     = rphs_pkg::OP_READ;
                state_next = rphs_pkg::ST_TMX;
            end
            rphs_pkg::ST_TMX:
            begin
                cmd.op     = rphs_pkg::OP_MUL_FX;
                track_next = 1'b0;
                state_next = rphs_pkg::ST_TANG;
            end
            rphs_pkg::ST_TANG:
            begin
                cmd.op     = rphs_pkg::OP_TERM_ANG;
                state_next = rphs_pkg::ST_CPREP;
            end
            rphs_pkg::ST_TMA:
            begin
                cmd.op     = rphs_pkg::OP_MUL_AMP;
                state_next = rphs_pkg::ST_TACC;
            end
            rphs_pkg::ST_TACC:
            begin
                cmd.op = rphs_pkg::OP_ACC;
                if (!track_reg)
                begin
                    track_next = 1'b1;
                    state_next = rphs_pkg::ST_TANG;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    track_next = 1'b0;
                    state_next = (idx_reg + CW'(1) == n_reg) ? rphs_pkg::ST_SMH
                                                             : rphs_pkg::ST_TRD;
                end
            end
            rphs_pkg::ST_SMH:
            begin
                cmd.op     = rphs_pkg::OP_MUL_SC_HI;
                state_next = rphs_pkg::ST_SHI;
            end
            rphs_pkg::ST_SHI:
            begin
                cmd.op     = rphs_pkg::OP_SC_HI;
                state_next = rphs_pkg::ST_SML;
            end
            rphs_pkg::ST_SML:
            begin
                cmd.op     = rphs_pkg::OP_MUL_SC_LO;
                state_next = rphs_pkg::ST_SOUT;
            end
            rphs_pkg::ST_SOUT:
            begin
                cmd.op = rphs_pkg::OP_SC_OUT;
                if (!track_reg)
                begin
                    track_next = 1'b1;
                    state_next = rphs_pkg::ST_SMH;
                end
                else
                begin
                    state_next = rphs_pkg::ST_PUB;
                end
            end
            rphs_pkg::ST_PUB:
            begin
                if (status.out_free)
                begin
                    cmd.op     = rphs_pkg::OP_PUBLISH;
                    state_next = rphs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rphs_pkg::ST_IDLE;
            end
        endcase
    end

    // Table reads stay within the loaded term count
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rphs_pkg::ST_TRD) |-> (idx_reg < n_reg))
        else $error("term index beyond term count");

    // Horner loop never runs past the last coefficient
    a_horner_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rphs_pkg::ST_CHS) |-> (h_cnt_reg <= 3'd4))
        else $error("Horner step out of range");

    // An evaluate always leaves idle for the fade ramps
    a_eval_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rphs_pkg::ST_IDLE && in_accept && in_op == rphs_pkg::OP_KIND_EVAL)
        |=> (state_reg == rphs_pkg::ST_RCHK))
        else $error("evaluate not started");

endmodule

>>> sv/road_profile_harmonic_synth_unit.sv
// Top level: stream ports, APB configuration registers, controller and datapath.
// Load transfers are taken one per cycle while the unit is idle and may follow back to back.
// Evaluate: each fade ramp holding the position strictly inside runs the divider and a cosine,
//   then each of min(term_count, MAX_TERMS) terms runs one cosine per track; next item taken once published.
// All steps share one multiplier and one cosine sequencer, beside a bit-a-cycle divider.
// Reset clears control state and loads register defaults; the term table is undefined until written.
`timescale 1ns / 1ps

module road_profile_harmonic_synth_unit #(
    parameter int MAX_TERMS = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    // Input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,  // term_index, amplitude, spatial_frequency,
                                        // left_phase, right_phase, position_x, zero pad
    input  logic         s_axis_tuser,  // op
    // Result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // height_left, height_right
    // Configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    logic [10:0] term_count_reg, term_count_next;
    logic [31:0] track_end_reg, track_end_next;
    logic [31:0] fade_length_reg, fade_length_next;
    logic        cfg_write;
    logic        in_accept;
    logic        in_ready;

    rphs_pkg::dp_cmd_t    cmd;
    rphs_pkg::dp_status_t status;
    logic [AW-1:0]        rd_addr;

    assign pready        = 1'b1;
    assign cfg_write     = psel && penable && pwrite && pready;
    assign s_axis_tready = in_ready;
    assign in_accept     = s_axis_tvalid && in_ready;

    // Register write decode
    always_comb
    begin
        term_count_next  = term_count_reg;
        track_end_next   = track_end_reg;
        fade_length_next = fade_length_reg;
        if (cfg_write)
        begin
            unique case (paddr[3:2])
                rphs_pkg::REG_TERM_COUNT:  term_count_next  = pwdata[10:0];
                rphs_pkg::REG_TRACK_END:   track_end_next   = pwdata;
                rphs_pkg::REG_FADE_LENGTH: fade_length_next = pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg  <= rphs_pkg::TERM_COUNT_RST;
            track_end_reg   <= rphs_pkg::TRACK_END_RST;
            fade_length_reg <= rphs_pkg::FADE_LENGTH_RST;
        end
        else
        begin
            term_count_reg  <= term_count_next;
            track_end_reg   <= track_end_next;
            fade_length_reg <= fade_length_next;
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (paddr[3:2])
            rphs_pkg::REG_TERM_COUNT:  prdata = {21'd0, term_count_reg};
            rphs_pkg::REG_TRACK_END:   prdata = track_end_reg;
            rphs_pkg::REG_FADE_LENGTH: prdata = fade_length_reg;
            default:                   prdata = '0;
        endcase
    end

    rphs_ctrl #(
        .MAX_TERMS(MAX_TERMS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_accept  (in_accept),
        .in_op      (s_axis_tuser),
        .in_ready   (in_ready),
        .term_count (term_count_reg),
        .status     (status),
        .cmd        (cmd),
        .rd_addr    (rd_addr)
    );

    rphs_dp #(
        .MAX_TERMS(MAX_TERMS)
    ) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .status               (status),
        .rd_addr              (rd_addr),
        .in_accept            (in_accept),
        .in_op                (s_axis_tuser),
        .in_term_index        (s_axis_tdata[9:0]),
        .in_amplitude         (s_axis_tdata[41:10]),
        .in_spatial_frequency (s_axis_tdata[73:42]),
        .in_left_phase        (s_axis_tdata[89:74]),
        .in_right_phase       (s_axis_tdata[105:90]),
        .in_position_x        (s_axis_tdata[137:106]),
        .track_end            (track_end_reg),
        .fade_length          (fade_length_reg),
        .out_valid            (m_axis_tvalid),
        .out_ready            (m_axis_tready),
        .out_data             (m_axis_tdata)
    );

endmodule
